// File: hw/rtl/assert_macros.svh
// assertion macros used by the top level of the console cursor block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/tcc_pkg.sv
// types, constants and helpers shared by the console cursor block
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    // glyph cell geometry and tab step
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int TAB_STEP     = 4;

    // clamp limits of the screen size registers
    localparam logic [8:0] COLS_MAX = 9'd256;
    localparam logic [7:0] ROWS_MAX = 8'd128;

    // special character codes
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;

    // configuration register indexes
    localparam logic [1:0] CFG_SCREEN_COLS = 2'd0;
    localparam logic [1:0] CFG_SCREEN_ROWS = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_FG  = 2'd2;
    localparam logic [1:0] CFG_DEFAULT_BG  = 2'd3;

    // command codes
    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_CLEAR      = 2'd2
    } command_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DRAW   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CLEAR  = 2'd2
    } kind_t;

    // one input request
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  glyph;
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        logic [7:0]  column;
        logic [6:0]  row;
    } item_t;

    // one draw request towards the renderer
    typedef struct packed {
        kind_t       kind;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  cell_glyph;
        logic [23:0] cell_fg;
        logic [23:0] cell_bg;
        logic        last;
    } result_t;

    // configuration register contents
    typedef struct packed {
        logic [8:0]  screen_cols;
        logic [7:0]  screen_rows;
        logic [23:0] default_fg;
        logic [23:0] default_bg;
    } cfg_t;

    // left pixel of a text column, kept to 12 bits
    function automatic logic [11:0] col_px(input logic [7:0] col);
        return 12'({4'b0, col} * 12'(GLYPH_WIDTH));
    endfunction

    // top pixel of a text row, kept to 12 bits
    function automatic logic [11:0] row_px(input logic [7:0] row);
        return 12'({4'b0, row} * 12'(GLYPH_HEIGHT));
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/text_console_cursor.sv
// top level of the text console cursor block
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | command glyph fg_color bg_color column row
//  out     | output    | out_valid / out_ready| kind pixel_x pixel_y cell_glyph cell_fg cell_bg last
//  cfg     | input     | cfg_we               | cfg_index cfg_data
//
// one request a cycle while the buffer does not hold it off: it is registered in the input
// register, then the cursor logic places its zero to two results in a two-slot result buffer;
// after a request with two results the next one with results waits until one result is left
// and out_ready is high; the single result port drains one result a cycle while ready
// reset puts the cursor at the origin and the registers at 80 x 25, white on black
// a stalled output holds the buffer; requests with no results still pass, the first
// one with results waits in the input register and holds off the input
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [23:0] cfg_data,

    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  command,
    input  wire  [7:0]  glyph,
    input  wire  [23:0] fg_color,
    input  wire  [23:0] bg_color,
    input  wire  [7:0]  column,
    input  wire  [6:0]  row,

    output logic        out_valid,
    input  wire         out_ready,
    output logic [1:0]  kind,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    output logic [7:0]  cell_glyph,
    output logic [23:0] cell_fg,
    output logic [23:0] cell_bg,
    output logic        last
);

    tcc_pkg::cfg_t    cfg_reg;
    logic [7:0]       cursor_col_reg;
    logic [7:0]       cursor_row_reg;
    logic             s_valid_reg;
    logic             s_valid_next;
    tcc_pkg::item_t   s_item_reg;
    tcc_pkg::result_t slot0_reg;
    tcc_pkg::result_t slot0_next;
    tcc_pkg::result_t slot1_reg;
    tcc_pkg::result_t slot1_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    tcc_pkg::result_t res0;
    tcc_pkg::result_t res1;
    logic [1:0]       n_res;
    logic [7:0]       new_col;
    logic [7:0]       new_row;
    logic             in_accept;
    logic             pop;
    logic             advance;
    logic             load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_cols <= 9'd80;
            cfg_reg.screen_rows <= 8'd25;
            cfg_reg.default_fg  <= 24'hFFFFFF;
            cfg_reg.default_bg  <= 24'h000000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcc_pkg::CFG_SCREEN_COLS: cfg_reg.screen_cols <= cfg_data[8:0];
                tcc_pkg::CFG_SCREEN_ROWS: cfg_reg.screen_rows <= cfg_data[7:0];
                tcc_pkg::CFG_DEFAULT_FG:  cfg_reg.default_fg  <= cfg_data;
                tcc_pkg::CFG_DEFAULT_BG:  cfg_reg.default_bg  <= cfg_data;
            endcase
        end
    end

    // cursor logic on the registered request
    tcc_step u_step (
        .item       (s_item_reg),
        .cfg        (cfg_reg),
        .cursor_col (cursor_col_reg),
        .cursor_row (cursor_row_reg),
        .res0       (res0),
        .res1       (res1),
        .n_res      (n_res),
        .new_col    (new_col),
        .new_row    (new_row)
    );

    // handshake and buffer control
    assign pop       = out_valid && out_ready;
    assign advance   = s_valid_reg &&
                       ((n_res == 2'd0) || (cnt_reg == 2'd0) ||
                        ((cnt_reg == 2'd1) && out_ready));
    assign load      = advance && (n_res != 2'd0);
    assign in_ready  = !s_valid_reg || advance;
    assign in_accept = in_valid && in_ready;

    // input register
    always_comb
    begin
        if (in_accept)
            s_valid_next = 1'b1;
        else if (advance)
            s_valid_next = 1'b0;
        else
            s_valid_next = s_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_valid_reg <= 1'b0;
        else
            s_valid_reg <= s_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_item_reg.command  <= command;
            s_item_reg.glyph    <= glyph;
            s_item_reg.fg_color <= fg_color;
            s_item_reg.bg_color <= bg_color;
            s_item_reg.column   <= column;
            s_item_reg.row      <= row;
        end
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= 8'd0;
            cursor_row_reg <= 8'd0;
        end
        else if (advance)
        begin
            cursor_col_reg <= new_col;
            cursor_row_reg <= new_row;
        end
    end

    // two-slot result buffer, slot 0 faces the output
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (load)
        begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = n_res;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // output ports
    assign out_valid  = (cnt_reg != 2'd0);
    assign kind       = slot0_reg.kind;
    assign pixel_x    = slot0_reg.pixel_x;
    assign pixel_y    = slot0_reg.pixel_y;
    assign cell_glyph = slot0_reg.cell_glyph;
    assign cell_fg    = slot0_reg.cell_fg;
    assign cell_bg    = slot0_reg.cell_bg;
    assign last       = slot0_reg.last;

    // checks on buffer and cursor bookkeeping
    `ASSERT_CLK(a_cnt_range, cnt_reg <= 2'd2, "result buffer count out of range")
    `ASSERT_IMPL(a_load_empty, load, (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop), "load over pending result")
    `ASSERT_IMPL(a_pair_last, cnt_reg == 2'd2, !slot0_reg.last && slot1_reg.last, "bad last marks on pair")
    `ASSERT_IMPL(a_single_last, cnt_reg == 2'd1, slot0_reg.last, "single result without last")
    `ASSERT_CLK(a_row_bound, cursor_row_reg <= tcc_pkg::ROWS_MAX, "cursor row beyond one past last row")

endmodule

`default_nettype wire

// File: hw/rtl/tcc_step.sv
// cursor update and draw request generation for one console request
`timescale 1ns / 1ps
`default_nettype none

module tcc_step (
    input  wire tcc_pkg::item_t   item,
    input  wire tcc_pkg::cfg_t    cfg,
    input  wire logic [7:0]       cursor_col,
    input  wire logic [7:0]       cursor_row,
    output tcc_pkg::result_t      res0,
    output tcc_pkg::result_t      res1,
    output logic [1:0]            n_res,
    output logic [7:0]            new_col,
    output logic [7:0]            new_row
);

    logic [8:0]       eff_cols;
    logic [7:0]       eff_rows;
    logic [7:0]       last_row;
    logic [7:0]       last_col;
    logic             need_scroll;
    logic [7:0]       c0;
    logic [7:0]       r0;
    logic [8:0]       c_inc;
    logic [8:0]       c_tab;
    logic [8:0]       r_inc;
    logic [7:0]       c_dec;
    tcc_pkg::result_t scroll_res;
    tcc_pkg::result_t clear_res;
    tcc_pkg::result_t ev_res;
    logic             ev_valid;

    // screen size clamped to its legal range
    always_comb
    begin
        if (cfg.screen_cols == 9'd0)
            eff_cols = 9'd1;
        else if (cfg.screen_cols > tcc_pkg::COLS_MAX)
            eff_cols = tcc_pkg::COLS_MAX;
        else
            eff_cols = cfg.screen_cols;

        if (cfg.screen_rows == 8'd0)
            eff_rows = 8'd1;
        else if (cfg.screen_rows > tcc_pkg::ROWS_MAX)
            eff_rows = tcc_pkg::ROWS_MAX;
        else
            eff_rows = cfg.screen_rows;
    end

    assign last_row = eff_rows - 8'd1;
    assign last_col = 8'(eff_cols - 9'd1);

    // cursor as seen after a possible leading scroll
    assign need_scroll = (cursor_row >= eff_rows);
    assign c0          = need_scroll ? 8'd0 : cursor_col;
    assign r0          = need_scroll ? last_row : cursor_row;
    assign c_inc       = {1'b0, c0} + 9'd1;
    assign c_tab       = {1'b0, c0} + 9'(tcc_pkg::TAB_STEP);
    assign r_inc       = {1'b0, r0} + 9'd1;
    assign c_dec       = c0 - 8'd1;

    // fixed shapes of the scroll and clear requests
    always_comb
    begin
        scroll_res.kind       = tcc_pkg::KIND_SCROLL;
        scroll_res.pixel_x    = 12'd0;
        scroll_res.pixel_y    = tcc_pkg::row_px(last_row);
        scroll_res.cell_glyph = tcc_pkg::CHAR_SPACE;
        scroll_res.cell_fg    = cfg.default_fg;
        scroll_res.cell_bg    = cfg.default_bg;
        scroll_res.last       = 1'b0;

        clear_res.kind        = tcc_pkg::KIND_CLEAR;
        clear_res.pixel_x     = 12'd0;
        clear_res.pixel_y     = 12'd0;
        clear_res.cell_glyph  = tcc_pkg::CHAR_SPACE;
        clear_res.cell_fg     = cfg.default_fg;
        clear_res.cell_bg     = cfg.default_bg;
        clear_res.last        = 1'b1;
    end

    // command decode, cursor movement and request selection
    always_comb
    begin
        ev_res             = scroll_res;
        ev_res.cell_fg     = item.fg_color;
        ev_res.cell_bg     = item.bg_color;
        ev_res.kind        = tcc_pkg::KIND_DRAW;
        ev_valid           = 1'b0;
        new_col            = cursor_col;
        new_row            = cursor_row;
        res0               = scroll_res;
        res1               = scroll_res;
        n_res              = 2'd0;

        unique case (tcc_pkg::command_t'(item.command))
            tcc_pkg::CMD_SET_CURSOR:
            begin
                if (({1'b0, item.column} < eff_cols) && ({1'b0, item.row} < eff_rows))
                begin
                    new_col = item.column;
                    new_row = {1'b0, item.row};
                end
            end
            tcc_pkg::CMD_CLEAR:
            begin
                res0  = clear_res;
                n_res = 2'd1;
            end
            tcc_pkg::CMD_PUT_CHAR:
            begin
                new_col = c0;
                new_row = r0;
                priority if (item.glyph == tcc_pkg::CHAR_NEWLINE)
                begin
                    if (r_inc >= {1'b0, eff_rows})
                    begin
                        ev_res   = scroll_res;
                        ev_valid = 1'b1;
                        new_col  = 8'd0;
                        new_row  = last_row;
                    end
                    else
                    begin
                        new_col = 8'd0;
                        new_row = r_inc[7:0];
                    end
                end
                else if (item.glyph == tcc_pkg::CHAR_BACKSPACE)
                begin
                    if (c0 == 8'd0 && r0 == 8'd0)
                    begin
                        ev_valid = 1'b0;
                    end
                    else if (c0 == 8'd0)
                    begin
                        // wrap back to the last cell of the row above
                        ev_res.pixel_x    = tcc_pkg::col_px(last_col);
                        ev_res.pixel_y    = tcc_pkg::row_px(r0 - 8'd1);
                        ev_res.cell_glyph = tcc_pkg::CHAR_SPACE;
                        ev_valid          = 1'b1;
                        new_col           = last_col;
                        new_row           = r0 - 8'd1;
                    end
                    else
                    begin
                        ev_res.pixel_x    = tcc_pkg::col_px(c_dec);
                        ev_res.pixel_y    = tcc_pkg::row_px(r0);
                        ev_res.cell_glyph = tcc_pkg::CHAR_SPACE;
                        ev_valid          = 1'b1;
                        if ({1'b0, c_dec} < eff_cols)
                            new_col = c_dec;
                    end
                end
                else if (item.glyph == tcc_pkg::CHAR_TAB)
                begin
                    if (c_tab >= eff_cols)
                        new_col = last_col;
                    else
                        new_col = c_tab[7:0];
                end
                else
                begin
                    // printable glyph, then advance with wrap
                    ev_res.pixel_x    = tcc_pkg::col_px(c0);
                    ev_res.pixel_y    = tcc_pkg::row_px(r0);
                    ev_res.cell_glyph = item.glyph;
                    ev_valid          = 1'b1;
                    if (c_inc >= eff_cols)
                    begin
                        new_col = 8'd0;
                        new_row = r_inc[7:0];
                    end
                    else
                    begin
                        new_col = c_inc[7:0];
                    end
                end

                // order the leading scroll before the command's own request
                ev_res.last = 1'b1;
                if (need_scroll)
                begin
                    res0      = scroll_res;
                    res0.last = !ev_valid;
                    res1      = ev_res;
                    n_res     = ev_valid ? 2'd2 : 2'd1;
                end
                else
                begin
                    res0  = ev_res;
                    res1  = ev_res;
                    n_res = ev_valid ? 2'd1 : 2'd0;
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
    end

endmodule

`default_nettype wire
